// ===== design/bfdh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdh_pkg: shared types and constants
// Transaction structs, hash constants and controller/datapath interface.
// ----------------------------------------------------------------------------
package bfdh_pkg;

  localparam int unsigned BITS_MAX_DEF   = 65536;
  localparam int unsigned HASHES_MAX_DEF = 30;

  localparam int unsigned K_W      = 5;
  localparam int unsigned BC_W     = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W    = 7;

  localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT  = 2'd1;

  localparam logic [K_W-1:0]  HASH_COUNT_RST = 5'd6;
  localparam logic [BC_W-1:0] BIT_COUNT_RST  = 17'd65536;
  localparam int unsigned     BITS_MIN       = 64;

  localparam logic [63:0] FNV_OFFSET = 64'hCBF29CE484222325;
  localparam logic [63:0] MIX_MUL_A  = 64'hFF51AFD7ED558CCD;
  localparam logic [63:0] MIX_MUL_B  = 64'hC4CEB9FE1A85EC53;
  localparam int unsigned MIX_SHIFT  = 33;

  localparam logic        CMD_ADD   = 1'b0;
  localparam logic        CMD_QUERY = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] key_byte;
    logic       byte_valid;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic was_query;
    logic maybe_present;
  } out_item_t;

  typedef struct packed {
    logic       clr_write;
    logic       mix_load;
    logic       mul_step;
    logic       mul_sel_b;
    logic [1:0] mul_chunk;
    logic       mul_end;
    logic       div_start;
    logic       div_step;
    logic       mem_write;
    logic       mem_read;
    logic       miss;
    logic       probe_next;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic last_probe;
    logic rd_bit;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// ===== design/bloom_filter_double_hash_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_core: streamed-key Bloom filter, double hashing
//
//   channel | ports                          | accepted when
//   input   | in_valid, in_stall, in_data    | in_valid && !in_stall
//   result  | out_valid, out_stall, out_data | out_valid && !out_stall
//   config  | cfg_we, cfg_index, cfg_wdata   | cfg_we
//
// Key bytes are taken while the block is idle. On the last byte the key is
// mixed, then each probe runs a 64-step serial modulo and a memory access
// (a write for an add; a read and a check for a query, which ends at the
// first clear bit), and the result is loaded once the result port is free.
// After reset all BITS_MAX bits of the filter memory are swept clear, in_stall
// high throughout. A stalled result holds the block before its next key ends.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_core
  import bfdh_pkg::*;
#(
  parameter int unsigned BITS_MAX   = BITS_MAX_DEF,
  parameter int unsigned HASHES_MAX = HASHES_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BC_W-1:0]      cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     idle;
  logic     in_go;

  assign in_stall = !idle;
  assign in_go    = in_valid && idle;

  bfdh_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_go (in_go && in_data.last_byte),
    .stat  (stat),
    .cmd   (cmd),
    .idle  (idle)
  );

  bfdh_dp #(
    .BITS_MAX   (BITS_MAX),
    .HASHES_MAX (HASHES_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_go     (in_go),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== design/bfdh_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdh_ctrl: sequencing controller
// Clearing sweep, murmur mix steps, serial modulo and per-probe memory access.
// ----------------------------------------------------------------------------
module bfdh_ctrl
  import bfdh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_go,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     idle
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_DIV    = 7'b0001000,
    S_ACCESS = 7'b0010000,
    S_CHECK  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(10);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(64);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    idle      = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        idle = 1'b1;
        if (in_go) begin
          state_nxt = S_MUL;
          cnt_nxt   = '0;
        end
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '0) begin
          cmd.mix_load = 1'b1;
        end else if (cnt_r <= CNT_W'(4)) begin
          cmd.mul_step  = 1'b1;
          cmd.mul_chunk = 2'(cnt_r - CNT_W'(1));
        end else if (cnt_r == CNT_W'(5) || cnt_r == MUL_LAST) begin
          cmd.mul_end = 1'b1;
        end else begin
          cmd.mul_step  = 1'b1;
          cmd.mul_sel_b = 1'b1;
          cmd.mul_chunk = 2'(cnt_r - CNT_W'(6));
        end
        if (cnt_r == MUL_LAST) begin
          state_nxt = S_DIV;
          cnt_nxt   = '0;
        end
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '0) cmd.div_start = 1'b1;
        else             cmd.div_step  = 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = S_ACCESS;
      end
      S_ACCESS: begin
        cnt_nxt = '0;
        if (stat.is_query) begin
          cmd.mem_read = 1'b1;
          state_nxt    = S_CHECK;
        end else begin
          cmd.mem_write = 1'b1;
          if (stat.last_probe) begin
            state_nxt = S_DONE;
          end else begin
            cmd.probe_next = 1'b1;
            state_nxt      = S_DIV;
          end
        end
      end
      S_CHECK: begin
        cnt_nxt = '0;
        if (!stat.rd_bit) begin
          cmd.miss  = 1'b1;
          state_nxt = S_DONE;
        end else if (stat.last_probe) begin
          state_nxt = S_DONE;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_DIV;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

  div_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r <= DIV_LAST))
    else $error("modulo step count overran");

  mul_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (cnt_r <= MUL_LAST))
    else $error("mix step count overran");

  access_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACCESS) |-> ($past(state_r) == S_DIV))
    else $error("memory access without a finished modulo");

endmodule

// ===== design/bfdh_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdh_dp: hash and probe datapath
// FNV-1a accumulator, murmur finalizer by 64x16 partial products, bit-serial
// modulo, filter bit memory and result register.
// ----------------------------------------------------------------------------
module bfdh_dp
  import bfdh_pkg::*;
#(
  parameter int unsigned BITS_MAX   = BITS_MAX_DEF,
  parameter int unsigned HASHES_MAX = HASHES_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_go,
  input  in_item_t             in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BC_W-1:0]      cfg_wdata,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  localparam int unsigned AW = (BITS_MAX > 1) ? $clog2(BITS_MAX) : 1;
  localparam int unsigned MW = $clog2(BITS_MAX + 1);

  logic [K_W-1:0]  hash_count_r;
  logic [BC_W-1:0] bit_count_r;
  logic [63:0]     run_hash_r, h1_r, v_r, acc_r, s_r, q_r;
  logic [K_W-1:0]  k_r, pidx_r;
  logic [MW-1:0]   m_r;
  logic [MW:0]     rem_r;
  logic            cmd_r, present_r, rd_r;
  logic [AW-1:0]   clr_addr_r;
  logic            out_valid_r;
  out_item_t       out_r;
  logic            mem_r [BITS_MAX];

  logic [63:0] hash_upd;
  logic [31:0] k_eff, m_eff, bc32;
  logic [15:0] mul_c;
  logic [63:0] prod;
  logic [63:0] part;
  logic [MW:0] trial;

  always_comb begin
    hash_upd = in_data.byte_valid ? fnv_step(run_hash_r, in_data.key_byte) : run_hash_r;
    k_eff = {27'd0, hash_count_r};
    if (k_eff < 32'd1) k_eff = 32'd1;
    if (k_eff > HASHES_MAX) k_eff = HASHES_MAX;
    bc32 = {15'd0, bit_count_r};
    m_eff = bc32;
    if (m_eff < BITS_MIN) m_eff = BITS_MIN;
    if (m_eff > BITS_MAX) m_eff = BITS_MAX;
    mul_c = cmd.mul_sel_b ? MIX_MUL_B[{cmd.mul_chunk, 4'b0} +: 16]
                          : MIX_MUL_A[{cmd.mul_chunk, 4'b0} +: 16];
    prod  = v_r * {48'd0, mul_c};
    part  = prod << {cmd.mul_chunk, 4'b0};
    trial = {rem_r[MW-1:0], q_r[63]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_count_r <= HASH_COUNT_RST;
      bit_count_r  <= BIT_COUNT_RST;
      run_hash_r   <= FNV_OFFSET;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_HASH_COUNT) hash_count_r <= cfg_wdata[K_W-1:0];
      if (cfg_we && cfg_index == REG_BIT_COUNT)  bit_count_r  <= cfg_wdata;
      if (in_go) run_hash_r <= in_data.last_byte ? FNV_OFFSET : hash_upd;
      if (cmd.clr_write) clr_addr_r <= clr_addr_r + 1'b1;
      if (cmd.out_load)              out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go && in_data.last_byte) begin
      h1_r  <= hash_upd;
      cmd_r <= in_data.command;
      k_r   <= k_eff[K_W-1:0];
      m_r   <= m_eff[MW-1:0];
    end
    if (cmd.mix_load) begin
      v_r       <= h1_r ^ (h1_r >> MIX_SHIFT);
      acc_r     <= '0;
      s_r       <= h1_r;
      pidx_r    <= '0;
      present_r <= 1'b1;
    end
    if (cmd.mul_step) acc_r <= acc_r + part;
    if (cmd.mul_end) begin
      v_r   <= acc_r ^ (acc_r >> MIX_SHIFT);
      acc_r <= '0;
    end
    if (cmd.div_start) begin
      q_r   <= s_r;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      q_r   <= q_r << 1;
      rem_r <= (trial >= {1'b0, m_r}) ? trial - {1'b0, m_r} : trial;
    end
    if (cmd.probe_next) begin
      s_r    <= s_r + (v_r | 64'd1);
      pidx_r <= pidx_r + 1'b1;
    end
    if (cmd.miss) present_r <= 1'b0;
    if (cmd.out_load) begin
      out_r.was_query     <= cmd_r;
      out_r.maybe_present <= (cmd_r == CMD_QUERY) && present_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_write)      mem_r[clr_addr_r]    <= 1'b0;
    else if (cmd.mem_write) mem_r[rem_r[AW-1:0]] <= 1'b1;
    if (cmd.mem_read) rd_r <= mem_r[rem_r[AW-1:0]];
  end

  assign stat.clr_last   = (clr_addr_r == AW'(BITS_MAX - 1));
  assign stat.is_query   = (cmd_r == CMD_QUERY);
  assign stat.last_probe = (pidx_r == k_r - 1'b1);
  assign stat.rd_bit     = rd_r;
  assign stat.out_busy   = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

  rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mem_write || cmd.mem_read) |-> (rem_r < {1'b0, m_r}))
    else $error("probe position not below bit count");

  probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mem_write || cmd.mem_read) |-> (pidx_r < k_r))
    else $error("probe index beyond probe count");

  no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("pending result overwritten");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for bloom_filter_double_hash_core
// Streams key bytes in random bursts against a randomly stalling receiver,
// predicts each add/query outcome with a local FNV-1a / murmur double-hash
// filter model, and compares every result transaction field by field. The
// probe count and filter size are changed between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
  import bfdh_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned LONG_HOLD = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BC_W-1:0] cfg_wdata = '0;

  always #10 clk = ~clk;

  bloom_filter_double_hash_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // filter model state
  logic [K_W-1:0] probes_reg = HASH_COUNT_RST;
  logic [BC_W-1:0] size_reg = BIT_COUNT_RST;
  logic [63:0] key_hash = FNV_OFFSET;
  bit filter_mem [0:BITS_MAX_DEF-1];

  out_item_t pending_answers[$];
  int unsigned errors = 0;
  int unsigned keys_added = 0;
  int unsigned keys_queried = 0;
  int unsigned hits_seen = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_cnt = 0;

  function automatic logic [63:0] finalize_mix(input logic [63:0] v);
    v = v ^ (v >> MIX_SHIFT);
    v = v * MIX_MUL_A;
    v = v ^ (v >> MIX_SHIFT);
    v = v * MIX_MUL_B;
    v = v ^ (v >> MIX_SHIFT);
    return v;
  endfunction

  // fold one transaction into the filter model; returns 1 when a result is due
  function automatic bit filter_predict(input in_item_t it, output out_item_t ans);
    logic [63:0] h1, h2, m, pos, i, k;
    bit present;
    present = 1'b1;
    ans = '0;
    if (it.byte_valid) key_hash = (key_hash ^ {56'd0, it.key_byte}) * FNV_PRIME;
    if (!it.last_byte) return 1'b0;
    h1 = key_hash;
    h2 = finalize_mix(h1) | 64'd1;
    k = (probes_reg == 0) ? 64'd1 : (probes_reg > HASHES_MAX_DEF) ? 64'd30 : 64'(probes_reg);
    m = (size_reg < BITS_MIN) ? 64'd64 :
        (size_reg > BITS_MAX_DEF) ? 64'(BITS_MAX_DEF) : 64'(size_reg);
    for (i = 0; i < k; i++) begin
      pos = (h1 + i * h2) % m;
      if (it.command == CMD_QUERY) begin
        if (!filter_mem[pos]) begin
          present = 1'b0;
          break;
        end
      end else begin
        filter_mem[pos] = 1'b1;
      end
    end
    key_hash = FNV_OFFSET;
    ans.was_query = it.command;
    ans.maybe_present = (it.command == CMD_QUERY) ? present : 1'b0;
    return 1'b1;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BC_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_HASH_COUNT) probes_reg = val[K_W-1:0];
    else if (idx == REG_BIT_COUNT) size_reg = val;
  endtask

  // sender: bursts with random gaps, one transaction per call
  int unsigned burst_left = 0;
  task automatic send_item(input in_item_t it, input bit fixed, input out_item_t want);
    out_item_t ans;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (filter_predict(it, ans)) begin
      if (it.command == CMD_QUERY) keys_queried++;
      else keys_added++;
      if (fixed) ans = want;
      pending_answers = {pending_answers, ans};
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // receiver: checks results and stalls on its own pattern
  always @(posedge clk) begin
    out_item_t exp_ans;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result transaction: was_query=%0b maybe_present=%0b",
               out_data.was_query, out_data.maybe_present);
        errors++;
      end else begin
        exp_ans = pending_answers.pop_front();
        if (out_data.was_query !== exp_ans.was_query) begin
          $error("was_query: expected %0b, got %0b", exp_ans.was_query, out_data.was_query);
          errors++;
        end
        if (out_data.maybe_present !== exp_ans.maybe_present) begin
          $error("maybe_present: expected %0b, got %0b",
                 exp_ans.maybe_present, out_data.maybe_present);
          errors++;
        end
        if (out_data.was_query && out_data.maybe_present) hits_seen++;
      end
    end
    if (mode_cnt == 0) begin
      mode_cnt = $urandom_range(16, 128);
      stall_mode = $urandom_range(0, 2);
    end
    mode_cnt--;
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt = LONG_HOLD;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // directed rows: {fixed, was_query, maybe_present, command, key_byte, byte_valid, last_byte}
  logic [13:0] directed_rows [0:14] = '{
    {1'b1, 2'b10, CMD_QUERY, 8'h00, 1'b0, 1'b1},
    {1'b1, 2'b00, CMD_ADD,   8'h00, 1'b0, 1'b1},
    {1'b0, 2'b00, CMD_QUERY, 8'h00, 1'b0, 1'b1},
    {1'b0, 2'b00, CMD_ADD,   8'h00, 1'b1, 1'b0},
    {1'b1, 2'b00, CMD_ADD,   8'hFF, 1'b1, 1'b1},
    {1'b0, 2'b00, CMD_QUERY, 8'h00, 1'b1, 1'b0},
    {1'b0, 2'b00, CMD_QUERY, 8'h55, 1'b0, 1'b0},
    {1'b0, 2'b00, CMD_QUERY, 8'hFF, 1'b1, 1'b1},
    {1'b0, 2'b00, CMD_QUERY, 8'hAA, 1'b1, 1'b0},
    {1'b1, 2'b00, CMD_ADD,   8'h7F, 1'b1, 1'b1},
    {1'b0, 2'b00, CMD_ADD,   8'hAA, 1'b1, 1'b0},
    {1'b0, 2'b00, CMD_QUERY, 8'h7F, 1'b1, 1'b1},
    {1'b0, 2'b00, CMD_QUERY, 8'h01, 1'b1, 1'b1},
    {1'b0, 2'b00, CMD_QUERY, 8'hFE, 1'b1, 1'b0},
    {1'b0, 2'b00, CMD_QUERY, 8'h01, 1'b1, 1'b1}
  };

  logic [K_W-1:0] phase_probes [0:NUM_PHASES-1] = '{5'd1, 5'd30, 5'd0, 5'd31, 5'd4, 5'd12};
  logic [BC_W-1:0] phase_size [0:NUM_PHASES-1] =
    '{17'd64, 17'd65536, 17'd63, 17'h1FFFF, 17'd100, 17'd0};

  initial begin
    in_item_t it;
    out_item_t want;
    int unsigned sent, key_id, key_len, p;
    bit rand_key;
    for (int a = 0; a < BITS_MAX_DEF; a++) filter_mem[a] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      it = directed_rows[r][10:0];
      want = directed_rows[r][12:11];
      send_item(it, directed_rows[r][13], want);
    end
    drain();

    sent = 0;
    for (p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_HASH_COUNT, (p == 4) ? BC_W'($urandom_range(1, 30)) : BC_W'(phase_probes[p]));
      write_reg(REG_BIT_COUNT, (p == 4) ? BC_W'($urandom_range(64, 65536)) : phase_size[p]);
      write_reg(REG_SPARE, BC_W'($urandom));
      if (p == 2) hold_req = 1'b1;
      while (sent < 125 * (p + 1)) begin
        // mostly keys from a small pool so queries hit, some fully random
        rand_key = ($urandom_range(0, 4) == 0);
        key_id = $urandom_range(0, 15);
        key_len = rand_key ? $urandom_range(0, 8) : (key_id % 6);
        for (int j = 0; j <= key_len; j++) begin
          if ($urandom_range(0, 9) == 0) begin
            it = '0;
            it.command = 1'($urandom);
            it.key_byte = 8'($urandom);
            send_item(it, 1'b0, '0);
          end
          it.command = 1'($urandom);
          it.key_byte = rand_key ? 8'($urandom) : 8'(key_id * 37 + j * 11);
          it.byte_valid = (key_len != 0);
          it.last_byte = (j == key_len);
          send_item(it, 1'b0, '0);
          sent++;
        end
      end
      drain();
    end

    $display("Covered %0d adds and %0d queries (%0d hits) over %0d settings phases.",
             keys_added, keys_queried, hits_seen, NUM_PHASES);
    if (pending_answers.size() != 0) begin
      $error("%0d expected results never arrived", pending_answers.size());
      errors++;
    end
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bfdh_pkg.sv
design/bfdh_ctrl.sv
design/bfdh_dp.sv
design/bloom_filter_double_hash_core.sv
tb/sv/tb_top.sv
